// ===== hw/rtl/rcwct_pkg.sv =====
// ----------------------------------------------------------------------------
// Raycast wall column texel package
// Shared types, widths and constants of the wall column texel pipeline.
// ----------------------------------------------------------------------------
package rcwct_pkg;

  localparam int unsigned DIST_W = 26;
  localparam int unsigned DIR_W = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned TEX_W = 11;
  localparam logic [DIST_W-1:0] NEAR_LIMIT = 26'd6;

  localparam logic [CFG_IDX_W-1:0] REG_CEILING_FILL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FLOOR_FILL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TEXTURE_WIDTH = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TEXTURE_HEIGHT = 2'd3;

  localparam logic [1:0] KIND_CEILING = 2'd0;
  localparam logic [1:0] KIND_WALL = 2'd1;
  localparam logic [1:0] KIND_FLOOR = 2'd2;
  localparam logic [1:0] KIND_NONE = 2'd3;

  localparam logic [1:0] PICK_NORTH = 2'd0;
  localparam logic [1:0] PICK_SOUTH = 2'd1;
  localparam logic [1:0] PICK_EAST = 2'd2;
  localparam logic [1:0] PICK_WEST = 2'd3;

  typedef struct packed {
    logic [11:0] column_index;
    logic [8:0] row_index;
    logic [25:0] hit_distance;
    logic hit_side;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic [25:0] viewer_x;
    logic [25:0] viewer_y;
  } in_item_t;

  typedef struct packed {
    logic [11:0] out_column;
    logic [8:0] out_row;
    logic [1:0] pixel_kind;
    logic [31:0] fill_color;
    logic [1:0] texture_pick;
    logic [9:0] texel_col;
    logic [9:0] texel_row;
  } out_item_t;

  function automatic logic [10:0] clamp_size(input logic [10:0] v);
    logic [10:0] r;
    r = v;
    if (v == 11'd0) begin
      r = 11'd1;
    end else if (v > 11'd1024) begin
      r = 11'd1024;
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/raycast_wall_column_texel.sv =====
// ----------------------------------------------------------------------------
// Raycast wall column texel
// Classifies one screen pixel of a raycast column and computes its texel.
// ----------------------------------------------------------------------------
// One pixel enters per clock while the output is not stalled. The pipe is
// made of four single register stages and two restoring dividers of one
// quotient bit per stage, RW + 16 stages for the wall height and RW + 28
// for the texel row, where RW is clog2(SCREEN_ROWS) + 1. The whole pipe
// advances together, so a stall at the output holds every stage and nothing
// is lost.
module raycast_wall_column_texel #(
  parameter int unsigned SCREEN_ROWS = 512
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  rcwct_pkg::in_item_t                 in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output rcwct_pkg::out_item_t                out_data_o,
  input  logic                                cfg_we_i,
  input  logic [rcwct_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [rcwct_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import rcwct_pkg::*;

  localparam int unsigned RW = $clog2(SCREEN_ROWS) + 1;
  localparam int unsigned HNUM_W = RW + 16;
  localparam int unsigned TNUM_W = HNUM_W + 1 + TEX_W;
  localparam logic [RW-1:0] ROWS = RW'(SCREEN_ROWS);
  localparam logic [RW-1:0] HALF = RW'(SCREEN_ROWS / 2);

  typedef struct packed {
    logic [11:0] col;
    logic [8:0] row;
    logic near;
    logic [1:0] pick;
    logic [9:0] tcol;
  } side_a_t;

  typedef struct packed {
    logic [11:0] col;
    logic [8:0] row;
    logic [1:0] kind;
    logic [1:0] pick;
    logic [9:0] tcol;
    logic zero_h;
    logic neg;
  } side_b_t;

  logic [31:0] ceil_q, floor_q;
  logic [10:0] tw_q, th_q, tw_c, th_c;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ceil_q <= '0;
      floor_q <= '0;
      tw_q <= 11'd64;
      th_q <= 11'd64;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_CEILING_FILL: ceil_q <= cfg_data_i;
        REG_FLOOR_FILL: floor_q <= cfg_data_i;
        REG_TEXTURE_WIDTH: tw_q <= cfg_data_i[10:0];
        REG_TEXTURE_HEIGHT: th_q <= cfg_data_i[10:0];
        default: ;
      endcase
    end
  end

  assign tw_c = clamp_size(tw_q);
  assign th_c = clamp_size(th_q);

  // Output register with the pipe enable derived from it.
  logic out_vld_q;
  out_item_t out_q;
  logic en;
  assign en = !out_vld_q || out_ready_i;
  assign in_ready_o = en;
  assign out_valid_o = out_vld_q;
  assign out_data_o = out_q;

  // Stage 1: wall product.
  logic s1_vld_q;
  logic [11:0] s1_col_q;
  logic [8:0] s1_row_q;
  logic [25:0] s1_dist_q;
  logic [25:0] s1_pos_q;
  logic signed [42:0] s1_prod_q;
  logic [1:0] s1_pick_q;
  logic s1_mir_q;
  logic s1_near_q;

  logic signed [DIR_W-1:0] dir_sel;
  assign dir_sel = in_data_i.hit_side ? in_data_i.dir_x : in_data_i.dir_y;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (en) begin
      s1_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_col_q <= in_data_i.column_index;
      s1_row_q <= in_data_i.row_index;
      s1_dist_q <= in_data_i.hit_distance;
      s1_pos_q <= in_data_i.hit_side ? in_data_i.viewer_x : in_data_i.viewer_y;
      s1_prod_q <= $signed({1'b0, in_data_i.hit_distance}) * dir_sel;
      if (!in_data_i.hit_side) begin
        s1_pick_q <= (in_data_i.dir_x > 0) ? PICK_WEST : PICK_EAST;
        s1_mir_q <= in_data_i.dir_x < 0;
      end else begin
        s1_pick_q <= (in_data_i.dir_y < 0) ? PICK_SOUTH : PICK_NORTH;
        s1_mir_q <= in_data_i.dir_y > 0;
      end
      s1_near_q <= (in_data_i.hit_distance <= NEAR_LIMIT)
                   || ({4'b0, in_data_i.row_index} >= 13'(SCREEN_ROWS));
    end
  end

  // Stage 2: fraction and its scale by the texture width.
  logic s2_vld_q;
  logic [11:0] s2_col_q;
  logic [8:0] s2_row_q;
  logic [25:0] s2_dist_q;
  logic [40:0] s2_scaled_q;
  logic [1:0] s2_pick_q;
  logic s2_mir_q;
  logic s2_near_q;
  logic [29:0] frac;
  assign frac = 30'({s1_pos_q, 14'b0}) + 30'(s1_prod_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else if (en) begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_col_q <= s1_col_q;
      s2_row_q <= s1_row_q;
      s2_dist_q <= s1_dist_q;
      s2_scaled_q <= 41'(frac) * 41'(tw_c);
      s2_pick_q <= s1_pick_q;
      s2_mir_q <= s1_mir_q;
      s2_near_q <= s1_near_q;
    end
  end

  // Stage 3: texel column, then the height division.
  logic [10:0] tc_raw, tc_fin;
  assign tc_raw = s2_scaled_q[40:30];
  assign tc_fin = s2_mir_q ? (tw_c - tc_raw - 11'd1) : tc_raw;

  side_a_t a_in, a_out;
  logic a_vld;
  logic [HNUM_W-1:0] height;
  assign a_in = '{col: s2_col_q, row: s2_row_q, near: s2_near_q, pick: s2_pick_q,
                  tcol: tc_fin[9:0]};

  rcwct_divider #(
    .NumW (HNUM_W),
    .DenW (DIST_W),
    .SideW ($bits(side_a_t))
  ) u_height_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s2_vld_q),
    .num_i   ({ROWS, 16'b0}),
    .den_i   (s2_dist_q),
    .side_i  (a_in),
    .valid_o (a_vld),
    .quot_o  (height),
    .side_o  (a_out)
  );

  // Stage 4: row classification and texel row numerator.
  logic [HNUM_W-1:0] hh;
  logic [HNUM_W:0] start_w, end_w, r_w;
  logic [1:0] kind;
  logic [HNUM_W+1:0] num_s;
  assign hh = height >> 1;
  assign r_w = (HNUM_W + 1)'(a_out.row);
  always_comb begin
    start_w = (hh >= HNUM_W'(HALF)) ? '0 : (HNUM_W + 1)'(HALF) - {1'b0, hh};
    end_w = (HNUM_W + 1)'(HALF) + {1'b0, hh};
    if (end_w >= (HNUM_W + 1)'(ROWS)) begin
      end_w = (HNUM_W + 1)'(ROWS) - (HNUM_W + 1)'(1);
    end
    if (a_out.near) begin
      kind = KIND_NONE;
    end else if (r_w < start_w) begin
      kind = KIND_CEILING;
    end else if (r_w > end_w) begin
      kind = KIND_FLOOR;
    end else begin
      kind = KIND_WALL;
    end
    num_s = {1'b0, r_w} + {2'b0, hh} - (HNUM_W + 2)'(HALF);
  end

  logic s4_vld_q;
  side_b_t s4_side_q;
  logic [TNUM_W-1:0] s4_num_q;
  logic [HNUM_W-1:0] s4_height_q;

  function automatic logic [HNUM_W-1:0] s4_zero_fix(input logic [HNUM_W-1:0] h);
    return (h == '0) ? HNUM_W'(1) : h;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_vld_q <= 1'b0;
    end else if (en) begin
      s4_vld_q <= a_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s4_side_q <= '{col: a_out.col, row: a_out.row, kind: kind, pick: a_out.pick,
                     tcol: a_out.tcol, zero_h: height == '0,
                     neg: num_s[HNUM_W+1] || num_s == '0};
      s4_num_q <= TNUM_W'(num_s[HNUM_W:0]) * TNUM_W'(th_c);
      s4_height_q <= height;
    end
  end

  side_b_t b_out;
  logic b_vld;
  logic [TNUM_W-1:0] ty;

  rcwct_divider #(
    .NumW (TNUM_W),
    .DenW (HNUM_W),
    .SideW ($bits(side_b_t))
  ) u_row_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s4_vld_q),
    .num_i   (s4_num_q),
    .den_i   (s4_zero_fix(s4_height_q)),
    .side_i  (s4_side_q),
    .valid_o (b_vld),
    .quot_o  (ty),
    .side_o  (b_out)
  );

  // Final stage: texel row clamp and result assembly.
  logic [10:0] trow;
  always_comb begin
    if (b_out.zero_h || b_out.neg) begin
      trow = '0;
    end else if (ty >= TNUM_W'(th_c)) begin
      trow = th_c - 11'd1;
    end else begin
      trow = ty[10:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= b_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q.out_column <= b_out.col;
      out_q.out_row <= b_out.row;
      out_q.pixel_kind <= b_out.kind;
      case (b_out.kind)
        KIND_CEILING: out_q.fill_color <= ceil_q;
        KIND_FLOOR: out_q.fill_color <= floor_q;
        default: out_q.fill_color <= '0;
      endcase
      out_q.texture_pick <= (b_out.kind == KIND_WALL) ? b_out.pick : PICK_NORTH;
      out_q.texel_col <= (b_out.kind == KIND_WALL) ? b_out.tcol : '0;
      out_q.texel_row <= (b_out.kind == KIND_WALL) ? trow[9:0] : '0;
    end
  end

endmodule

// ===== hw/rtl/rcwct_divider.sv =====
// ----------------------------------------------------------------------------
// Raycast wall column texel pipelined divider
// Restoring unsigned divider, one quotient bit per stage, with a sideband
// payload and a valid bit that move in step with a shared stall.
// ----------------------------------------------------------------------------
module rcwct_divider #(
  parameter int unsigned NumW = 32,
  parameter int unsigned DenW = 26,
  parameter int unsigned SideW = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [NumW-1:0]  num_i,
  input  logic [DenW-1:0]  den_i,
  input  logic [SideW-1:0] side_i,
  output logic             valid_o,
  output logic [NumW-1:0]  quot_o,
  output logic [SideW-1:0] side_o
);

  logic vld_q [NumW];
  logic [NumW-1:0] quot_q [NumW];
  logic [DenW-1:0] rem_q [NumW];
  logic [DenW-1:0] den_q [NumW];
  logic [SideW-1:0] side_q [NumW];

  for (genvar s = 0; s < NumW; s++) begin : g_stage
    logic vld_d;
    logic [NumW-1:0] quot_d;
    logic [DenW-1:0] rem_d;
    logic [DenW-1:0] den_d;
    logic [SideW-1:0] side_d;
    logic [DenW+1:0] trial;
    logic [DenW+1:0] shifted;

    if (s == 0) begin : g_first
      assign vld_d = valid_i;
      assign quot_d = num_i;
      assign rem_d = '0;
      assign den_d = den_i;
      assign side_d = side_i;
    end else begin : g_next
      assign vld_d = vld_q[s-1];
      assign quot_d = quot_q[s-1];
      assign rem_d = rem_q[s-1];
      assign den_d = den_q[s-1];
      assign side_d = side_q[s-1];
    end

    assign shifted = {1'b0, rem_d, quot_d[NumW-1]};
    assign trial = shifted - {2'b00, den_d};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en_i) begin
        vld_q[s] <= vld_d;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!trial[DenW+1]) begin
          rem_q[s] <= trial[DenW-1:0];
        end else begin
          rem_q[s] <= shifted[DenW-1:0];
        end
        quot_q[s] <= {quot_d[NumW-2:0], ~trial[DenW+1]};
        den_q[s] <= den_d;
        side_q[s] <= side_d;
      end
    end
  end

  assign valid_o = vld_q[NumW-1];
  assign quot_o = quot_q[NumW-1];
  assign side_o = side_q[NumW-1];

endmodule

// ===== bench/tb_raycast_wall_column_texel.sv =====
// ----------------------------------------------------------------------------
// Raycast wall column texel testbench
// Drives directed and random pixels through the wall column pipeline, checks
// every result against a predictor, and changes the registers between phases.
// ----------------------------------------------------------------------------
module tb_raycast_wall_column_texel;
  import rcwct_pkg::*;

  localparam int unsigned ROWS = 512;
  localparam int unsigned DRAIN_CYCLES = 200;
  localparam longint unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned RANDOM_ITEMS = 1500;
  localparam int unsigned HOLD_CYCLES = 300;

  typedef struct {
    logic [11:0] col;
    logic [8:0]  row;
    logic [25:0] hit_dist;
    logic        side;
    logic [15:0] dx;
    logic [15:0] dy;
    logic [25:0] vx;
    logic [25:0] vy;
    logic        known;
    logic [1:0]  kind;
    logic [31:0] fill;
  } pixel_row_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_item_t in_data;
  logic out_valid;
  logic out_ready;
  out_item_t out_data;
  logic cfg_we;
  logic [1:0] cfg_idx;
  logic [31:0] cfg_data;

  logic [31:0] ceiling_reg;
  logic [31:0] floor_reg;
  logic [10:0] tex_w_reg;
  logic [10:0] tex_h_reg;

  out_item_t texel_queue[$];
  int unsigned mismatches;
  int unsigned results_seen;
  int unsigned items_sent;
  longint unsigned cycles = 0;
  logic hold_off;
  logic hold_done = 1'b0;
  logic quiet;

  raycast_wall_column_texel dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_data_o(out_data),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic logic [10:0] size_clamped(input logic [10:0] v);
    if (v == 11'd0) return 11'd1;
    if (v > 11'd1024) return 11'd1024;
    return v;
  endfunction

  function automatic out_item_t predict_texel(input in_item_t p);
    out_item_t o;
    longint height, start_row, end_row, r, num, dir, wall;
    longint unsigned w, h, pos, frac, tcol, ty;
    o = '0;
    o.out_column = p.column_index;
    o.out_row = p.row_index;
    o.pixel_kind = KIND_NONE;
    if (p.hit_distance > NEAR_LIMIT && p.row_index < ROWS) begin
      height = (longint'(ROWS) << 16) / longint'(p.hit_distance);
      start_row = ROWS / 2 - height / 2;
      end_row = ROWS / 2 + height / 2;
      r = longint'(p.row_index);
      if (start_row < 0) start_row = 0;
      if (end_row >= ROWS) end_row = ROWS - 1;
      if (r < start_row) begin
        o.pixel_kind = KIND_CEILING;
        o.fill_color = ceiling_reg;
      end else if (r > end_row) begin
        o.pixel_kind = KIND_FLOOR;
        o.fill_color = floor_reg;
      end else begin
        w = size_clamped(tex_w_reg);
        h = size_clamped(tex_h_reg);
        pos = p.hit_side ? p.viewer_x : p.viewer_y;
        dir = p.hit_side ? longint'(p.dir_x) : longint'(p.dir_y);
        wall = longint'(pos << 14) + longint'(p.hit_distance) * dir;
        frac = longint'(wall) & ((64'd1 << 30) - 1);
        o.pixel_kind = KIND_WALL;
        if (!p.hit_side) o.texture_pick = (p.dir_x > 0) ? PICK_WEST : PICK_EAST;
        else o.texture_pick = (p.dir_y < 0) ? PICK_SOUTH : PICK_NORTH;
        tcol = (frac * w) >> 30;
        if ((!p.hit_side && p.dir_x < 0) || (p.hit_side && p.dir_y > 0))
          tcol = w - tcol - 1;
        o.texel_col = tcol[9:0];
        ty = 0;
        if (height > 0) begin
          num = r - ROWS / 2 + height / 2;
          if (num > 0) ty = (longint'(num) * h) / longint'(height);
          if (ty >= h) ty = h - 1;
        end
        o.texel_row = ty[9:0];
      end
    end
    return o;
  endfunction

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_CEILING_FILL:   ceiling_reg = val;
      REG_FLOOR_FILL:     floor_reg = val;
      REG_TEXTURE_WIDTH:  tex_w_reg = val[10:0];
      default:            tex_h_reg = val[10:0];
    endcase
    @(posedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (texel_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic send_pixel(input in_item_t p, input out_item_t expected, input bit typed);
    out_item_t pred;
    while (!quiet && $urandom_range(99) < 15) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    pred = predict_texel(p);
    if (typed && (pred.pixel_kind != expected.pixel_kind ||
        pred.fill_color != expected.fill_color)) begin
      mismatches++;
      if (mismatches <= 10)
        $display("directed row disagrees: kind %0d/%0d", expected.pixel_kind,
                 pred.pixel_kind);
    end
    in_valid <= 1'b1;
    in_data <= p;
    texel_queue.push_back(pred);
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  function automatic in_item_t random_pixel();
    in_item_t p;
    p = '0;
    p.column_index = 12'($urandom);
    p.row_index = 9'($urandom);
    case ($urandom_range(5))
      0: p.hit_distance = 26'($urandom_range(8));
      1: p.hit_distance = 26'($urandom);
      2: p.hit_distance = 26'($urandom_range(200000, 7));
      default: p.hit_distance = 26'($urandom_range(2000000, 20000));
    endcase
    p.hit_side = 1'($urandom);
    p.dir_x = 16'($urandom);
    p.dir_y = 16'($urandom);
    p.viewer_x = 26'($urandom);
    p.viewer_y = 26'($urandom);
    return p;
  endfunction

  initial begin
    pixel_row_t plan[$];
    pixel_row_t e;
    in_item_t p;
    out_item_t x;
    int unsigned k;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_data = '0;
    hold_off = 1'b0;
    quiet = 1'b0;
    ceiling_reg = 32'd0;
    floor_reg = 32'd0;
    tex_w_reg = 11'd64;
    tex_h_reg = 11'd64;
    mismatches = 0;
    results_seen = 0;
    items_sent = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed rows: col, row, dist, side, dx, dy, vx, vy, known, kind, fill.
    plan = '{
      '{12'd0, 9'd0, 26'd0, 1'b0, 16'h0000, 16'h0000, 26'd0, 26'd0, 1'b1, KIND_NONE, 0},
      '{12'hFFF, 9'd200, 26'd6, 1'b1, 16'h7FFF, 16'h8000, '1, '1, 1'b1, KIND_NONE, 0},
      '{12'd5, 9'd256, 26'd7, 1'b0, 16'h4000, 16'h4000, 26'd65536, 26'd65536, 1'b0, 0, 0},
      '{12'd6, 9'd0, '1, 1'b0, 16'h8000, 16'h7FFF, '1, 26'd0, 1'b1, KIND_CEILING, 0},
      '{12'd7, 9'd511, '1, 1'b1, 16'h7FFF, 16'h7FFF, 26'd0, '1, 1'b1, KIND_FLOOR, 0},
      '{12'd8, 9'd256, '1, 1'b1, 16'h8000, 16'h8000, 26'd3, 26'd9, 1'b0, 0, 0},
      '{12'd9, 9'd511, 26'd65536, 1'b0, 16'hC000, 16'h1234, 26'd1, 26'd77777, 1'b0, 0, 0},
      '{12'd10, 9'd0, 26'd65536, 1'b1, 16'h0001, 16'h0001, 26'd99999, 26'd0, 1'b0, 0, 0},
      '{12'd11, 9'd300, 26'd131072, 1'b0, 16'h0000, 16'hFFFF, 26'd12345, 26'd54321, 1'b0, 0, 0},
      '{12'd12, 9'd300, 26'd131072, 1'b1, 16'hFFFF, 16'h0000, 26'd12345, 26'd54321, 1'b0, 0, 0},
      '{12'd13, 9'd256, 26'd40000000, 1'b0, 16'h2000, 16'hE000, 26'd5, 26'd5, 1'b0, 0, 0}
    };
    for (k = 0; k < plan.size(); k++) begin
      e = plan[k];
      p = '{e.col, e.row, e.hit_dist, e.side, e.dx, e.dy, e.vx, e.vy};
      x = '0;
      x.pixel_kind = e.kind;
      x.fill_color = e.fill;
      send_pixel(p, x, e.known);
    end
    wait_drained();

    write_reg(REG_CEILING_FILL, 32'hFFFFFFFF);
    write_reg(REG_FLOOR_FILL, 32'hA5A5_5A5A);
    write_reg(REG_TEXTURE_WIDTH, 32'd0);
    write_reg(REG_TEXTURE_HEIGHT, 32'd2047);
    for (k = 0; k < 6; k++) begin
      p = random_pixel();
      p.hit_distance = 26'(200000 + k);
      p.row_index = (k < 3) ? 9'd0 : 9'd511;
      x = '0;
      x.pixel_kind = (k < 3) ? KIND_CEILING : KIND_FLOOR;
      x.fill_color = (k < 3) ? 32'hFFFFFFFF : 32'hA5A5_5A5A;
      send_pixel(p, x, 1'b1);
    end

    for (k = 0; k < RANDOM_ITEMS; k++) begin
      if (k % 300 == 0) begin
        wait_drained();
        write_reg(REG_CEILING_FILL, $urandom);
        write_reg(REG_FLOOR_FILL, $urandom);
        case ((k / 300) % 4)
          0: begin write_reg(REG_TEXTURE_WIDTH, 1); write_reg(REG_TEXTURE_HEIGHT, 1); end
          1: begin write_reg(REG_TEXTURE_WIDTH, 1024); write_reg(REG_TEXTURE_HEIGHT, 1024); end
          2: begin
            write_reg(REG_TEXTURE_WIDTH, $urandom_range(2047));
            write_reg(REG_TEXTURE_HEIGHT, $urandom_range(2047));
          end
          default: begin write_reg(REG_TEXTURE_WIDTH, 64); write_reg(REG_TEXTURE_HEIGHT, 37); end
        endcase
      end
      quiet = (k >= 600 && k < 800);
      hold_off = (k >= 900);
      send_pixel(random_pixel(), '0, 1'b0);
    end
    wait_drained();
    $display("Sent %0d pixels over several register settings, checked %0d results.",
             items_sent, results_seen);
    if (mismatches == 0 && texel_queue.size() == 0) begin
      $display("tb_raycast_wall_column_texel: done, clean");
    end else begin
      $display("tb_raycast_wall_column_texel: done, errors");
    end
    $finish;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_off && !hold_done) begin
      out_ready <= 1'b0;
      repeat (HOLD_CYCLES) @(posedge clk);
      out_ready <= 1'b1;
      hold_done = 1'b1;
    end else begin
      out_ready <= quiet ? 1'b1 : ($urandom_range(99) >= 15);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      out_item_t want;
      results_seen++;
      if (texel_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transfer: %h", out_data);
      end else begin
        want = texel_queue.pop_front();
        if (out_data !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch col %0d row %0d: expected %h, got %h",
                     want.out_column, want.out_row, want, out_data);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_raycast_wall_column_texel: done, errors");
      $finish;
    end
  end

endmodule

// ===== filelist.f =====
hw/rtl/rcwct_pkg.sv
hw/rtl/rcwct_divider.sv
hw/rtl/raycast_wall_column_texel.sv
bench/tb_raycast_wall_column_texel.sv
